>>> hdl/peak_to_peak_level_meter_core_assert.svh
// Assertion macros shared by the level meter RTL.
`ifndef PEAK_TO_PEAK_LEVEL_METER_CORE_ASSERT_SVH
`define PEAK_TO_PEAK_LEVEL_METER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PTP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define PTP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define PTP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PTP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/ptp_pkg.sv
// Types and constants of the peak-to-peak level meter.
package ptp_pkg;
   // configuration register map
   localparam int CSR_DATA_W = 16;
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_WINDOW_LENGTH = 1'd0;
   localparam csr_index_type CSR_LEVEL_OFFSET  = 1'd1;

   localparam int WINDOW_LENGTH_W = 12;
   localparam logic [WINDOW_LENGTH_W-1:0] WINDOW_LENGTH_RESET = 12'd2000;
   localparam int OFFSET_W = 16;
   localparam int LEVEL_W  = 16;

   // log2 datapath: operand up to 16 bits, Q1.15 mantissa, 16 fraction bits
   localparam int LOG_W  = 16;
   localparam int EXP_W  = 4;
   localparam int FRAC_W = 16;
   localparam int L_W    = EXP_W + FRAC_W;

   // 20*log10(2) and -20*log10(3.3/4095), both Q.16
   localparam int DBO_W = 19;
   localparam logic [DBO_W-1:0] DB_PER_OCTAVE_Q16 = 19'd394566;
   localparam int D_W = L_W + DBO_W - 16;
   localparam logic [D_W-1:0] FULL_SCALE_DB_Q16 = 23'd4055027;
   localparam int T_W = 27;

   localparam int QUEUE_DEPTH = 4;
endpackage

>>> hdl/ptp_req_if.sv
// Sample channel: valid, ready and one ADC sample per beat.
interface ptp_req_if #(parameter int SAMPLE_BITS = 12) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> hdl/ptp_rsp_if.sv
// Result channel: valid, ready, amplitude and level per beat.
interface ptp_rsp_if #(parameter int SAMPLE_BITS = 12) ();
   logic                         valid;
   logic                         ready;
   logic [SAMPLE_BITS-1:0]       amplitude;
   logic [ptp_pkg::LEVEL_W-1:0]  level_db;
   modport source (output valid, output amplitude, output level_db, input ready);
   modport sink (input valid, input amplitude, input level_db, output ready);
endinterface

>>> hdl/ptp_queue.sv
// Small FIFO of finished window amplitudes between front and back.
`include "peak_to_peak_level_meter_core_assert.svh"
module ptp_queue #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4   // power of two
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `PTP_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
endmodule

>>> hdl/ptp_front.sv
// Window tracker: running max/min and sample count, pushes amplitude at window end.
`include "peak_to_peak_level_meter_core_assert.svh"
module ptp_front #(
   parameter int SAMPLE_BITS = 12,
   parameter int MAX_WINDOW  = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ptp_req_if.sink                              req_if,
   input  logic [ptp_pkg::WINDOW_LENGTH_W-1:0]  window_length,
   output logic                                 push_valid,
   output logic [SAMPLE_BITS-1:0]               push_amp,
   input  logic                                 push_ready
);
   localparam int SEEN_W = $clog2(MAX_WINDOW);
   localparam int WL_W   = ptp_pkg::WINDOW_LENGTH_W;
   localparam int CMP_W  = ((SEEN_W + 1) > WL_W ? (SEEN_W + 1) : WL_W) + 1;

   logic [SAMPLE_BITS-1:0] max_ff, min_ff, max_in, min_in;
   logic [SEEN_W-1:0]      seen_ff;
   logic [CMP_W-1:0]       len_raw, eff_len;
   logic                   accept, close;

   assign req_if.ready = push_ready;
   assign accept       = req_if.valid && req_if.ready;

   // zero length acts as one, long windows clip to the maximum
   always_comb begin
      len_raw = CMP_W'(window_length);
      priority if (len_raw == '0)                  eff_len = CMP_W'(1);
      else if (len_raw > CMP_W'(MAX_WINDOW))       eff_len = CMP_W'(MAX_WINDOW);
      else                                         eff_len = len_raw;
   end

   assign max_in = (req_if.sample > max_ff) ? req_if.sample : max_ff;
   assign min_in = (req_if.sample < min_ff) ? req_if.sample : min_ff;
   assign close  = (CMP_W'(seen_ff) + CMP_W'(1)) >= eff_len;

   assign push_valid = accept && close;
   assign push_amp   = max_in - min_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         min_ff  <= '1;
         seen_ff <= '0;
      end else if (accept) begin
         if (close) begin
            max_ff  <= '0;
            min_ff  <= '1;
            seen_ff <= '0;
         end else begin
            max_ff  <= max_in;
            min_ff  <= min_in;
            seen_ff <= seen_ff + SEEN_W'(1);
         end
      end
   end

   `PTP_ASSERT_NXT(a_window_restart, clock, reset, push_valid, seen_ff == '0 && max_ff == '0)
endmodule

>>> hdl/ptp_back.sv
// Level pipeline: normalize, 16 squaring stages for log2, scale, offset, round and clamp.
`include "peak_to_peak_level_meter_core_assert.svh"
module ptp_back #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   input  logic [SAMPLE_BITS-1:0]         pop_data,
   output logic                           pop_ready,
   input  logic [ptp_pkg::OFFSET_W-1:0]   level_offset,
   ptp_rsp_if.source                      rsp_if
);
   localparam int LOG_W  = ptp_pkg::LOG_W;
   localparam int EXP_W  = ptp_pkg::EXP_W;
   localparam int FRAC_W = ptp_pkg::FRAC_W;
   localparam int L_W    = ptp_pkg::L_W;
   localparam int DBO_W  = ptp_pkg::DBO_W;
   localparam int D_W    = ptp_pkg::D_W;
   localparam int T_W    = ptp_pkg::T_W;
   localparam int LV_W   = ptp_pkg::LEVEL_W;

   logic en;

   // normalize inputs
   logic [LOG_W-1:0] v_in, mant_in;
   logic [EXP_W-1:0] exp_in;

   // squaring chain, index 0 is the normalized operand
   logic                   sq_vld_ff  [FRAC_W+1];
   logic                   sq_zero_ff [FRAC_W+1];
   logic [SAMPLE_BITS-1:0] sq_amp_ff  [FRAC_W+1];
   logic [EXP_W-1:0]       sq_exp_ff  [FRAC_W+1];
   logic [LOG_W-1:0]       sq_m_ff    [FRAC_W+1];
   logic [FRAC_W-1:0]      sq_frac_ff [FRAC_W+1];
   logic [2*LOG_W-1:0]     sq_prod    [FRAC_W+1];
   logic [LOG_W-1:0]       sq_m_in    [FRAC_W+1];
   logic [FRAC_W-1:0]      sq_frac_in [FRAC_W+1];

   // scale stage
   logic                   d_vld_ff, d_zero_ff;
   logic [SAMPLE_BITS-1:0] d_amp_ff;
   logic [D_W-1:0]         d_ff, d_in;
   logic [L_W+DBO_W-1:0]   d_prod;

   // offset stage
   logic                   t_vld_ff, t_zero_ff;
   logic [SAMPLE_BITS-1:0] t_amp_ff;
   logic signed [T_W-1:0]  t_ff, t_in, off_ext, t_rnd;

   // output register
   logic                   out_valid_ff;
   logic [SAMPLE_BITS-1:0] out_amp_ff;
   logic [LV_W-1:0]        out_level_ff, level_in;

   // whole pipeline advances together whenever the output slot frees up
   assign en        = !out_valid_ff || rsp_if.ready;
   assign pop_ready = en;

   always_comb begin
      v_in   = LOG_W'(pop_data);
      exp_in = '0;
      for (int i = 0; i < LOG_W; i++) begin
         if (v_in[i]) exp_in = EXP_W'(i);
      end
      mant_in = v_in << (EXP_W'(LOG_W - 1) - exp_in);
   end

   // square, renormalize into [1,2), shift one fraction bit in
   always_comb begin
      sq_prod[0]    = '0;
      sq_m_in[0]    = '0;
      sq_frac_in[0] = '0;
      for (int k = 1; k <= FRAC_W; k++) begin
         sq_prod[k] = sq_m_ff[k-1] * sq_m_ff[k-1];
         if (sq_prod[k][2*LOG_W-1]) begin
            sq_m_in[k]    = sq_prod[k][2*LOG_W-1:LOG_W];
            sq_frac_in[k] = {sq_frac_ff[k-1][FRAC_W-2:0], 1'b1};
         end else begin
            sq_m_in[k]    = sq_prod[k][2*LOG_W-2:LOG_W-1];
            sq_frac_in[k] = {sq_frac_ff[k-1][FRAC_W-2:0], 1'b0};
         end
      end
   end

   assign d_prod = {sq_exp_ff[FRAC_W], sq_frac_ff[FRAC_W]} * ptp_pkg::DB_PER_OCTAVE_Q16;
   assign d_in   = d_prod[L_W+DBO_W-1:16];

   always_comb begin
      off_ext = T_W'($signed(level_offset));
      t_in    = $signed(T_W'(d_ff)) - $signed(T_W'(ptp_pkg::FULL_SCALE_DB_Q16))
                + (off_ext <<< 8);
   end

   // round half up to Q8.8, clamp below zero, saturate above range
   always_comb begin
      t_rnd = t_ff + T_W'(128);
      priority if (t_zero_ff || t_ff <= 0)     level_in = '0;
      else if (t_rnd[T_W-2:8] > 18'd65535)     level_in = '1;
      else                                     level_in = t_rnd[LV_W+7:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FRAC_W; k++) sq_vld_ff[k] <= 1'b0;
         d_vld_ff     <= 1'b0;
         t_vld_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         sq_vld_ff[0] <= pop_valid;
         for (int k = 1; k <= FRAC_W; k++) sq_vld_ff[k] <= sq_vld_ff[k-1];
         d_vld_ff     <= sq_vld_ff[FRAC_W];
         t_vld_ff     <= d_vld_ff;
         out_valid_ff <= t_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_zero_ff[0] <= (pop_data == '0);
         sq_amp_ff[0]  <= pop_data;
         sq_exp_ff[0]  <= exp_in;
         sq_m_ff[0]    <= mant_in;
         sq_frac_ff[0] <= '0;
         for (int k = 1; k <= FRAC_W; k++) begin
            sq_zero_ff[k] <= sq_zero_ff[k-1];
            sq_amp_ff[k]  <= sq_amp_ff[k-1];
            sq_exp_ff[k]  <= sq_exp_ff[k-1];
            sq_m_ff[k]    <= sq_m_in[k];
            sq_frac_ff[k] <= sq_frac_in[k];
         end
         d_zero_ff    <= sq_zero_ff[FRAC_W];
         d_amp_ff     <= sq_amp_ff[FRAC_W];
         d_ff         <= d_in;
         t_zero_ff    <= d_zero_ff;
         t_amp_ff     <= d_amp_ff;
         t_ff         <= t_in;
         out_amp_ff   <= t_amp_ff;
         out_level_ff <= level_in;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.amplitude = out_amp_ff;
   assign rsp_if.level_db  = out_level_ff;

   `PTP_ASSERT_IMP(a_zero_amp_level, clock, reset, out_valid_ff && out_amp_ff == '0, out_level_ff == '0)
   `PTP_ASSERT_NXT(a_last_stage_out, clock, reset, en && t_vld_ff, out_valid_ff)
endmodule

>>> hdl/peak_to_peak_level_meter_core.sv
// Each result passes the queue and the normalize, squaring, scale, offset and output registers.
// Throughput: one sample and one result per cycle, even at window length 1, if rsp_if is ready;
// the log2 is a chain of 16 registered 16x16 squaring stages, so no stage iterates.
// A stalled result stalls the level pipeline; a 4-entry queue keeps samples flowing until full.
// Reset (synchronous, active high) restores window_length 2000, offset 0, clears the window
// and empties queue and pipeline; no clearing pass is needed.
module peak_to_peak_level_meter_core #(
   parameter int SAMPLE_BITS = 12,
   parameter int MAX_WINDOW  = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   ptp_req_if.sink                             req_if,
   ptp_rsp_if.source                           rsp_if,
   input  logic                                csr_write_enable,
   input  ptp_pkg::csr_index_type              csr_index,
   input  logic [ptp_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   logic [ptp_pkg::WINDOW_LENGTH_W-1:0] window_length_ff;
   logic [ptp_pkg::OFFSET_W-1:0]        level_offset_ff;

   // amplitude beats from the front into the queue, and from the queue to the back
   logic                   push_valid, push_ready;
   logic [SAMPLE_BITS-1:0] push_amp;
   logic                   pop_valid, pop_ready;
   logic [SAMPLE_BITS-1:0] pop_data;

   // Hold configuration; writes land immediately and do not restart a window.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= ptp_pkg::WINDOW_LENGTH_RESET;
         level_offset_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ptp_pkg::CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_write_data[ptp_pkg::WINDOW_LENGTH_W-1:0];
            end
            ptp_pkg::CSR_LEVEL_OFFSET: begin
               level_offset_ff <= csr_write_data[ptp_pkg::OFFSET_W-1:0];
            end
         endcase
      end
   end

   // Front: classify each sample beat, close windows, push the amplitude.
   ptp_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .window_length (window_length_ff),
      .push_valid    (push_valid),
      .push_amp      (push_amp),
      .push_ready    (push_ready)
   );

   // Queue: absorb result stalls so the front keeps accepting samples.
   ptp_queue #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (ptp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_amp),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // Back: turn each amplitude into a dB level and drive the result register.
   ptp_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_data     (pop_data),
      .pop_ready    (pop_ready),
      .level_offset (level_offset_ff),
      .rsp_if       (rsp_if)
   );
endmodule

>>> dv/tb_peak_to_peak_level_meter_core.sv
// Testbench for the peak-to-peak level meter core: table-driven and random samples vs a predictor.
module tb_peak_to_peak_level_meter_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS    = 12;
   localparam int MAX_WINDOW     = 2048;
   localparam int SETTLE_CYCLES  = 32;    // covers the result latency of the pipeline
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
   localparam int MISMATCH_PRINTS = 10;
   localparam int DIRECTED_ROWS  = 30;
   localparam int RANDOM_PHASES  = 12;
   localparam int PRESSURE_PHASE = 4;
   localparam int LONG_PHASE     = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int OPENING_SAMPLES = 40;

   localparam ptp_pkg::csr_index_type IDX_WIN = ptp_pkg::CSR_WINDOW_LENGTH;
   localparam ptp_pkg::csr_index_type IDX_OFS = ptp_pkg::CSR_LEVEL_OFFSET;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]      amplitude;
      logic [ptp_pkg::LEVEL_W-1:0] level_db;
   } meter_reading_type;

   typedef enum bit {ROW_CSR, ROW_SAMPLE} row_kind_type;

   // One line of the directed table: either a register write or a sample beat.
   // For a sample that closes a window, known marks a reading typed in by hand.
   typedef struct packed {
      row_kind_type                   kind;
      ptp_pkg::csr_index_type         index;
      logic [ptp_pkg::CSR_DATA_W-1:0] data;
      logic [SAMPLE_BITS-1:0]         sample;
      bit                             known;
      logic [SAMPLE_BITS-1:0]         amplitude;
      logic [ptp_pkg::LEVEL_W-1:0]    level_db;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   ptp_pkg::csr_index_type         csr_index;
   logic [ptp_pkg::CSR_DATA_W-1:0] csr_write_data;

   ptp_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   ptp_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   peak_to_peak_level_meter_core #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_WINDOW (MAX_WINDOW)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_bus),
      .rsp_if          (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // Predictor copy of the block: registers and the open window.
   logic [ptp_pkg::WINDOW_LENGTH_W-1:0] win_len;
   logic signed [ptp_pkg::OFFSET_W-1:0] lvl_ofs;
   logic [SAMPLE_BITS-1:0]              peak_hi;
   logic [SAMPLE_BITS-1:0]              peak_lo;
   int unsigned                         fill_count;

   meter_reading_type pending_readings[$];  // readings still owed by the block, oldest first
   int                mismatch_count;
   int                quiet_cycles;

   // Handoff from the sample driver to the monitor for hand-typed readings.
   bit                row_known;
   meter_reading_type row_reading;

   // Idling knobs, set per phase by the stimulus.
   int send_idle_pct;
   int rsp_stall_pct;
   int rsp_hold_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // log2 of a nonzero amplitude as unsigned Q.16: top set bit as the integer part,
   // fraction bits from repeated truncated squaring of the Q1.15 mantissa.
   function automatic logic [ptp_pkg::L_W-1:0] octave_log(input logic [SAMPLE_BITS-1:0] amp);
      logic [ptp_pkg::EXP_W-1:0]  ex;
      logic [ptp_pkg::FRAC_W-1:0] fr;
      logic [63:0]                m;
      int                         i;
      ex = '0;
      fr = '0;
      for (i = 0; i < SAMPLE_BITS; i++)
         if (amp[i]) ex = ptp_pkg::EXP_W'(i);
      m = 64'(amp) << (15 - ex);
      for (i = 0; i < ptp_pkg::FRAC_W; i++) begin
         m = (m * m) >> 15;
         fr = fr << 1;
         if (m >= 64'h1_0000) begin
            m = m >> 1;
            fr[0] = 1'b1;
         end
      end
      return {ex, fr};
   endfunction

   // Level in Q8.8 dB: scale the log to dB, drop full scale, add the offset,
   // clamp at zero, round half up and saturate.
   function automatic logic [ptp_pkg::LEVEL_W-1:0] level_for(
         input logic [SAMPLE_BITS-1:0] amp,
         input logic signed [ptp_pkg::OFFSET_W-1:0] ofs);
      longint db;
      if (amp == '0)
         return '0;
      db = longint'((64'(octave_log(amp)) * 64'(ptp_pkg::DB_PER_OCTAVE_Q16)) >> 16);
      db = db - longint'(ptp_pkg::FULL_SCALE_DB_Q16) + longint'(ofs) * 256;
      if (db <= 0)
         return '0;
      db = (db + 128) / 256;
      if (db > 65535)
         return '1;
      return db[ptp_pkg::LEVEL_W-1:0];
   endfunction

   // Fold one accepted sample into the window; closes says a reading is due.
   function automatic void absorb_sample(input logic [SAMPLE_BITS-1:0] s, output bit closes,
                                         output meter_reading_type reading);
      int unsigned span;
      span = (win_len == '0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
      if (s > peak_hi) peak_hi = s;
      if (s < peak_lo) peak_lo = s;
      reading = '0;
      closes = 1'b0;
      if (fill_count + 1 < span) begin
         fill_count++;
      end else begin
         closes = 1'b1;
         reading.amplitude = (peak_hi >= peak_lo) ? peak_hi - peak_lo : '0;
         reading.level_db = level_for(reading.amplitude, lvl_ofs);
         peak_hi = '0;
         peak_lo = '1;
         fill_count = 0;
      end
   endfunction

   function automatic void flag_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_PRINTS)
         $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
   endfunction

   // Mostly samples clustered around a center, so amplitudes spread over every level;
   // a quarter are full-range to toggle every bit.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int center, input int spread);
      int v;
      if ($urandom_range(0, 3) == 0)
         return SAMPLE_BITS'($urandom_range(0, 4095));
      v = center + int'($urandom_range(0, spread)) - spread / 2;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SAMPLE_BITS'(v);
   endfunction

   // Offer one sample beat; called and left at a falling edge, valid stays high.
   task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input bit known,
                              input meter_reading_type reading);
      row_known = known;
      row_reading = reading;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= s;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed reading is in, then let the pipeline empty.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register; the predictor copy follows at once.
   task automatic write_csr(input ptp_pkg::csr_index_type index,
                            input logic [ptp_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         ptp_pkg::CSR_WINDOW_LENGTH: win_len = data[ptp_pkg::WINDOW_LENGTH_W-1:0];
         ptp_pkg::CSR_LEVEL_OFFSET:  lvl_ofs = data[ptp_pkg::OFFSET_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
         default: begin send_idle_pct = 23; rsp_stall_pct = 23; end
      endcase
   endtask

   // Directed table. Hand-typed readings: zero amplitude gives 0 dB whatever the
   // offset, an amplitude of one sits far below 0 dB, and full amplitude with the most
   // negative offset clamps to zero. The rest is left to the predictor, including the
   // first sample, which closes the window left open at the reset length, and the
   // mid-window shortening of the window at the end.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_CSR,    IDX_WIN, 16'h0000, 12'd0,    1'b0, 12'd0,    16'd0}, // zero -> one
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd0,    1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'hFFF,  1'b1, 12'd0,    16'd0},
      '{ROW_CSR,    IDX_WIN, 16'hF001, 12'd0,    1'b0, 12'd0,    16'd0}, // top bits drop
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'hAAA,  1'b1, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'h555,  1'b1, 12'd0,    16'd0},
      '{ROW_CSR,    IDX_WIN, 16'h0002, 12'd0,    1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd0,    1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd1,    1'b1, 12'd1,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'hFFF,  1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd0,    1'b0, 12'd0,    16'd0},
      '{ROW_CSR,    IDX_OFS, 16'h7FFF, 12'd0,    1'b0, 12'd0,    16'd0}, // +128 dB
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd0,    1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'hFFF,  1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd7,    1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd7,    1'b1, 12'd0,    16'd0},
      '{ROW_CSR,    IDX_OFS, 16'h8000, 12'd0,    1'b0, 12'd0,    16'd0}, // -128 dB
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'hFFF,  1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd0,    1'b1, 12'hFFF,  16'd0},
      '{ROW_CSR,    IDX_OFS, 16'h0A00, 12'd0,    1'b0, 12'd0,    16'd0}, // +10 dB
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd100,  1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd2000, 1'b0, 12'd0,    16'd0},
      '{ROW_CSR,    IDX_WIN, 16'h0003, 12'd0,    1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd5,    1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd4000, 1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd17,   1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd10,   1'b0, 12'd0,    16'd0},
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd20,   1'b0, 12'd0,    16'd0},
      '{ROW_CSR,    IDX_WIN, 16'h0002, 12'd0,    1'b0, 12'd0,    16'd0}, // shrink open
      '{ROW_SAMPLE, IDX_WIN, 16'h0000, 12'd30,   1'b0, 12'd0,    16'd0}
   };

   // Receiver: a long hold-off when asked, otherwise random stalls per phase.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Monitor: predict on every accepted sample beat, check every accepted result beat
   // against the oldest owed reading, and watch for a hang.
   always @(posedge clock) begin : monitor
      meter_reading_type want;
      meter_reading_type got;
      bit                closes;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_sample(req_bus.sample, closes, want);
            if (closes)
               pending_readings.push_back(row_known ? row_reading : want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.amplitude = rsp_bus.amplitude;
            got.level_db = rsp_bus.level_db;
            if (pending_readings.size() == 0) begin
               flag_mismatch("unexpected reading, amplitude", -1, got.amplitude);
            end else begin
               want = pending_readings.pop_front();
               if (got.amplitude !== want.amplitude)
                  flag_mismatch("amplitude", want.amplitude, got.amplitude);
               if (got.level_db !== want.level_db)
                  flag_mismatch("level_db", want.level_db, got.level_db);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                                  ph;
      int                                  n;
      int                                  count;
      int                                  center;
      int                                  spread;
      logic [ptp_pkg::WINDOW_LENGTH_W-1:0] win;
      logic [ptp_pkg::OFFSET_W-1:0]        ofs;
      meter_reading_type                   blank_reading;

      blank_reading = '0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = ptp_pkg::CSR_WINDOW_LENGTH;
      csr_write_data = '0;
      row_known = 1'b0;
      row_reading = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 0;
      mismatch_count = 0;

      // predictor starts from the reset state of the block
      win_len = ptp_pkg::WINDOW_LENGTH_RESET;
      lvl_ofs = '0;
      peak_hi = '0;
      peak_lo = '1;
      fill_count = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Open a window at the reset length and offset; it stays short of closing.
      set_idling(0);
      center = $urandom_range(0, 4095);
      for (n = 0; n < OPENING_SAMPLES; n++)
         push_sample(pick_sample(center, 256), 1'b0, blank_reading);

      // Walk the directed table; writes wait for the block to go idle.
      for (n = 0; n < DIRECTED_ROWS; n++) begin
         if (directed_rows[n].kind == ROW_CSR) begin
            drain_results();
            write_csr(directed_rows[n].index, directed_rows[n].data);
         end else begin
            push_sample(directed_rows[n].sample, directed_rows[n].known,
                        meter_reading_type'{directed_rows[n].amplitude,
                                            directed_rows[n].level_db});
         end
      end

      // Random phases: each rewrites both registers mid-window, then streams samples.
      // The pressure phase runs window length one into a long receiver hold-off so
      // the queue backs up into the sample channel; the long phase leaves a window
      // open under an all-ones length, and the next phase shortens it under way.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         count = 48;
         if (ph == PRESSURE_PHASE) begin
            win = 12'd1;
            count = 80;
         end else if (ph == LONG_PHASE) begin
            win = '1;
            count = 100;
         end else if (ph % 5 == 2) begin
            win = ptp_pkg::WINDOW_LENGTH_W'($urandom_range(13, 64));
         end else begin
            win = ptp_pkg::WINDOW_LENGTH_W'($urandom_range(1, 12));
         end
         if ($urandom_range(0, 1))
            ofs = ptp_pkg::OFFSET_W'($urandom_range(0, 65535));
         else
            ofs = ptp_pkg::OFFSET_W'($urandom_range(0, 16'h2800)) - 16'h1400;

         drain_results();
         set_idling(ph % 4);
         write_csr(ptp_pkg::CSR_WINDOW_LENGTH, {4'($urandom_range(0, 15)), win});
         write_csr(ptp_pkg::CSR_LEVEL_OFFSET, ofs);
         if (ph == PRESSURE_PHASE) begin
            set_idling(0);
            rsp_hold_left = HOLD_OFF_CYCLES;
         end

         center = $urandom_range(0, 4095);
         spread = 1 << $urandom_range(0, 12);
         for (n = 0; n < count; n++)
            push_sample(pick_sample(center, spread), 1'b0, blank_reading);
      end

      drain_results();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hdl
hdl/ptp_pkg.sv
hdl/ptp_req_if.sv
hdl/ptp_rsp_if.sv
hdl/ptp_queue.sv
hdl/ptp_front.sv
hdl/ptp_back.sv
hdl/peak_to_peak_level_meter_core.sv
dv/tb_peak_to_peak_level_meter_core.sv
